>>> design/stepper_move_queue_pulse_gen_core_macros.svh
// Assertion macros shared by the checker files of the stepper move queue core.
// Include guard keeps a second inclusion harmless.
`ifndef STEPPER_MOVE_QUEUE_PULSE_GEN_CORE_MACROS_SVH
`define STEPPER_MOVE_QUEUE_PULSE_GEN_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SMQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/smq_pkg.sv
// Package of the stepper move queue core: sizes, command codes, timer constants.
// No dependencies.
package smq_pkg;
   localparam int QUEUE_DEPTH = 8;
   localparam int FREQ_SCALE  = 1;
   localparam int AXES        = 3;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;
   localparam logic [1:0] CMD_ZERO = 2'd3;

   localparam logic [37:0] NUMER    = 38'(64'd42000000 * 64'(FREQ_SCALE));
   localparam logic [23:0] FREQ_LO  = 24'(FREQ_SCALE);
   localparam logic [23:0] FREQ_HI  = 24'(15000 * FREQ_SCALE);
endpackage

>>> design/stepper_move_queue_pulse_gen_core.sv
// Three-axis step/direction generator with a move ring held in a memory.
// Depends on smq_pkg.
//
// Usage: one transaction on the req_ channel yields exactly one transaction on
// the rsp_ channel. req_command selects add move, timer tick, emergency stop
// or zero positions. An add converts each axis frequency into prescale and
// reload with one shared restoring divider: a 38-bit division per axis, then
// normalization by halving. A refused add, a stop or a zeroing goes straight
// to the output register, a tick first reads the move memory, and a tick
// that dequeues passes through one more state, because the move memory has a
// registered read port.
// One item is worked on at a time: req_stall is high from acceptance until
// its result enters the output register. The output register frees the core
// while a result waits; a new item is taken only once the previous result
// has been delivered or is being delivered in that cycle. rsp_stall holds the
// result steady. Synchronous reset clears pointers, counts, positions, timer
// settings and pins (step pins idle high, motors disabled); the move memory
// is not cleared since only written slots are ever read.
module stepper_move_queue_pulse_gen_core
   import smq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_axis,
   input  logic        req_limit_hit,
   input  logic [31:0] req_steps_x,
   input  logic [31:0] req_steps_y,
   input  logic [31:0] req_steps_z,
   input  logic [23:0] req_freq_x,
   input  logic [23:0] req_freq_y,
   input  logic [23:0] req_freq_z,
   input  logic        req_dir_x,
   input  logic        req_dir_y,
   input  logic        req_dir_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [3:0]  rsp_queue_fill,
   output logic        rsp_busy_res,
   output logic [2:0]  rsp_step_pins,
   output logic [2:0]  rsp_dir_pins,
   output logic        rsp_motors_enabled,
   output logic signed [31:0] rsp_axis_position,
   output logic [15:0] rsp_timer_prescale,
   output logic [15:0] rsp_timer_reload,
   output logic [2:0]  rsp_timer_loaded,
   output logic        rsp_stopped
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_NORM = 4'd2, S_WR = 4'd3,
                          S_RD = 4'd4, S_DQ = 4'd5, S_OUT = 4'd6;

   // One memory word: all axes of one move.
   typedef struct packed {
      logic [2:0][31:0] steps;
      logic [2:0][15:0] psc;
      logic [2:0][15:0] rld;
      logic [2:0]       dirs;
   } move_type;

   logic [3:0] state_ff;
   logic [1:0] cmd_ff, ax_ff;
   logic       lim_ff;
   logic [2:0][31:0] st_ff;
   logic [2:0][23:0] fr_ff;
   logic [2:0]       dr_ff;
   move_type         mv_ff;
   logic [1:0]  dax_ff;
   logic [5:0]  dcnt_ff;
   logic [37:0] quo_ff, rem_ff;
   logic [15:0] pre_ff;
   logic [QPTR_W-1:0]  rptr_ff, wptr_ff;
   logic [QFILL_W-1:0] fill_ff;
   logic [2:0][31:0] remain_ff, pos_ff;
   logic [2:0][15:0] apsc_ff, arld_ff;
   logic [2:0] phase_ff, run_ff, dirb_ff;
   logic       en_ff, acc_ff, stop_ff;
   logic [2:0] loaded_ff;
   logic       ovalid_ff;

   move_type mem [QUEUE_DEPTH];
   move_type rdata_ff;

   logic        accept, out_free;
   logic [23:0] fcl;
   logic [38:0] trial;
   logic        any_steps;

   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign any_steps = (req_steps_x | req_steps_y | req_steps_z) != 32'd0;

   // Clamped frequency of the axis under division.
   always_comb begin
      fcl = fr_ff[dax_ff];
      if (fcl > FREQ_HI) fcl = FREQ_HI;
      if (fcl < FREQ_LO) fcl = FREQ_LO;
      if (fcl == 24'd0)  fcl = 24'd1;
      trial = {rem_ff, quo_ff[37]} - {15'd0, fcl};
   end

   // Move memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == S_WR) mem[wptr_ff] <= mv_ff;
      rdata_ff <= mem[rptr_ff];
   end

   // Sequencer and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rptr_ff <= '0; wptr_ff <= '0; fill_ff <= '0;
         remain_ff <= '0; pos_ff <= '0; apsc_ff <= '0; arld_ff <= '0;
         phase_ff <= 3'b111; run_ff <= '0; dirb_ff <= '0; en_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (ovalid_ff && !rsp_stall && state_ff != S_OUT) ovalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff <= req_command; ax_ff <= req_axis; lim_ff <= req_limit_hit;
                  st_ff  <= {req_steps_z, req_steps_y, req_steps_x};
                  fr_ff  <= {req_freq_z, req_freq_y, req_freq_x};
                  dr_ff  <= {req_dir_z, req_dir_y, req_dir_x};
                  acc_ff <= 1'b0; loaded_ff <= '0;
                  stop_ff <= (req_command == CMD_STOP);
                  case (req_command)
                     CMD_ADD: begin
                        if (any_steps && fill_ff < QFILL_W'(QUEUE_DEPTH)) begin
                           dax_ff <= 2'd0; dcnt_ff <= '0; rem_ff <= '0;
                           quo_ff <= NUMER;
                           state_ff <= S_DIV;
                        end else state_ff <= S_OUT;
                     end
                     CMD_TICK: state_ff <= S_RD;
                     CMD_STOP: begin
                        remain_ff <= '0; run_ff <= '0; en_ff <= 1'b0;
                        rptr_ff <= '0; wptr_ff <= '0; fill_ff <= '0;
                        state_ff <= S_OUT;
                     end
                     default: begin
                        pos_ff <= '0; state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            // Restoring division, one quotient bit per cycle.
            S_DIV: begin
               if (!trial[38]) begin
                  rem_ff <= trial[37:0];
                  quo_ff <= {quo_ff[36:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[36:0], quo_ff[37]};
                  quo_ff <= {quo_ff[36:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 6'd1;
               pre_ff  <= 16'd1;
               if (dcnt_ff == 6'd37) state_ff <= S_NORM;
            end
            // Halve until the count fits 16 bits.
            S_NORM: begin
               if (quo_ff[37:16] != '0) begin
                  quo_ff <= quo_ff >> 1;
                  pre_ff <= {pre_ff[14:0], 1'b0};
               end else begin
                  mv_ff.psc[dax_ff] <= pre_ff - 16'd1;
                  mv_ff.rld[dax_ff] <= quo_ff[15:0];
                  if (dax_ff == 2'(AXES - 1)) begin
                     mv_ff.steps <= st_ff; mv_ff.dirs <= dr_ff;
                     state_ff <= S_WR;
                  end else begin
                     dax_ff <= dax_ff + 2'd1; dcnt_ff <= '0; rem_ff <= '0;
                     quo_ff <= NUMER; state_ff <= S_DIV;
                  end
               end
            end
            S_WR: begin
               wptr_ff <= (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
               fill_ff <= fill_ff + 1'b1;
               acc_ff <= 1'b1; state_ff <= S_OUT;
            end
            // Tick: memory read at rptr is in flight this cycle.
            S_RD: begin
               if (lim_ff) begin
                  remain_ff <= '0; run_ff <= '0; en_ff <= 1'b0;
                  rptr_ff <= '0; wptr_ff <= '0; fill_ff <= '0;
                  stop_ff <= 1'b1; state_ff <= S_OUT;
               end else if (ax_ff >= 2'(AXES)) begin
                  state_ff <= S_OUT;
               end else if (run_ff[ax_ff]) begin
                  if (!phase_ff[ax_ff]) begin
                     if (remain_ff[ax_ff] != 0) remain_ff[ax_ff] <= remain_ff[ax_ff] - 1;
                     pos_ff[ax_ff] <= dirb_ff[ax_ff] ? pos_ff[ax_ff] + 1 : pos_ff[ax_ff] - 1;
                  end else if (remain_ff[ax_ff] == 0) run_ff[ax_ff] <= 1'b0;
                  phase_ff[ax_ff] <= !phase_ff[ax_ff];
                  state_ff <= S_OUT;
               end else if (fill_ff != '0 && run_ff == '0) state_ff <= S_DQ;
               else state_ff <= S_OUT;
            end
            S_DQ: begin
               for (int i = 0; i < AXES; i++) begin
                  remain_ff[i] <= rdata_ff.steps[i];
                  if (rdata_ff.steps[i] != 0) begin
                     run_ff[i] <= 1'b1; dirb_ff[i] <= rdata_ff.dirs[i];
                     apsc_ff[i] <= rdata_ff.psc[i]; arld_ff[i] <= rdata_ff.rld[i];
                     loaded_ff[i] <= 1'b1;
                  end
               end
               if (rdata_ff.steps != '0) en_ff <= 1'b1;
               rptr_ff <= (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
               fill_ff <= fill_ff - 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  ovalid_ff <= 1'b1;
                  rsp_accepted <= acc_ff;
                  rsp_queue_fill <= 4'(fill_ff);
                  rsp_busy_res <= (fill_ff != '0) || (run_ff != '0);
                  rsp_step_pins <= phase_ff;
                  rsp_dir_pins <= dirb_ff;
                  rsp_motors_enabled <= en_ff;
                  rsp_timer_loaded <= loaded_ff;
                  rsp_stopped <= stop_ff;
                  if (ax_ff < 2'(AXES)) begin
                     rsp_axis_position <= pos_ff[ax_ff];
                     rsp_timer_prescale <= apsc_ff[ax_ff];
                     rsp_timer_reload <= arld_ff[ax_ff];
                  end else begin
                     rsp_axis_position <= '0;
                     rsp_timer_prescale <= '0;
                     rsp_timer_reload <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = ovalid_ff;
endmodule

>>> design/smq_checker.sv
// Port-level checker for the stepper move queue core, bound to its top level.
// Depends on smq_pkg and the shared assertion macros.
`include "stepper_move_queue_pulse_gen_core_macros.svh"
module smq_checker
   import smq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_accepted,
   input logic [3:0] rsp_queue_fill,
   input logic       rsp_busy_res,
   input logic       rsp_stopped,
   input logic       rsp_motors_enabled
);
   `SMQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SMQ_ASSERT_IMPL(a_fill_range, clock, reset, rsp_valid, rsp_queue_fill <= 4'(QUEUE_DEPTH))
   `SMQ_ASSERT_IMPL(a_stop_empty, clock, reset, rsp_valid && rsp_stopped,
      rsp_queue_fill == 4'd0 && !rsp_motors_enabled && !rsp_busy_res)
   `SMQ_ASSERT_IMPL(a_acc_busy, clock, reset, rsp_valid && rsp_accepted, rsp_busy_res)
   `SMQ_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind stepper_move_queue_pulse_gen_core smq_checker u_smq_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_accepted(rsp_accepted),
   .rsp_queue_fill(rsp_queue_fill), .rsp_busy_res(rsp_busy_res),
   .rsp_stopped(rsp_stopped), .rsp_motors_enabled(rsp_motors_enabled)
);
